// ----- rtl/core/ssecho_pkg.sv -----
// shared types and constants for the servo sweep and echo obstacle reporter
`timescale 1ns / 1ps

package ssecho_pkg;

  // rangefinder channels
  localparam int NumRangers = 4;
  localparam int ChBits     = 2;

  // field widths
  localparam int SampleBits = 12;
  localparam int AngleBits  = 8;
  localparam int StepBits   = 7;
  localparam int TimeBits   = 32;
  localparam int CountBits  = 8;
  localparam int CmpBits    = 12;
  localparam int ByteBits   = 8;

  // stream widths (whole bytes)
  localparam int InDataBits  = 48;
  localparam int OutDataBits = 24;

  // configuration port
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 8;

  // result queue
  localparam int FifoDepth = 4;
  localparam int PtrBits   = 2;
  localparam int FillBits  = 3;
  localparam int MaxRes    = 3;

  // reset values of the registers
  localparam logic signed [7:0] SweepMinRst  = -8'sd70;
  localparam logic signed [7:0] SweepMaxRst  = 8'sd70;
  localparam logic [6:0]        SweepStepRst = 7'd10;
  localparam logic [7:0]        NearThrRst   = 8'd2;
  localparam logic [7:0]        HystRst      = 8'd10;
  localparam logic [7:0]        StableRst    = 8'd2;
  localparam logic [3:0]        TrigMaskRst  = 4'd11;
  localparam logic [3:0]        DoneMaskRst  = 4'd11;
  localparam logic [7:0]        CountMax     = 8'd255;

  // servo compare offset and scale
  localparam logic signed [12:0] CmpScale  = 13'sd10;
  localparam logic signed [12:0] CmpOffset = 13'sd1500;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgSweepMin  = 3'd0,
    CfgSweepMax  = 3'd1,
    CfgSweepStep = 3'd2,
    CfgNearThr   = 3'd3,
    CfgHyst      = 3'd4,
    CfgStable    = 3'd5,
    CfgTrigMask  = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    ReqSweep = 1'b0,
    ReqEcho  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    KindServo = 2'd0,
    KindFlags = 2'd1,
    KindAngle = 2'd2
  } kind_e;

  // one result item
  typedef struct packed {
    kind_e                kind;
    logic [CmpBits-1:0]   compare;
    logic                 fire;
    logic [ByteBits-1:0]  payload;
    logic                 last;
  } result_t;

endpackage

// ----- rtl/core/servo_sweep_echo_obstacle_reporter_core.sv -----
// top level: servo sweep peak tracker and echo obstacle reporter
`timescale 1ns / 1ps

// Usage
//   s_axis carries input transactions: tuser selects a sweep step (0) or an
//   echo edge (1); tdata holds sample, channel, level and timestamp.
//   m_axis returns result transactions: tuser is the result kind, tlast marks
//   the last result caused by one input transaction.
//   cfg_we_i/cfg_idx_i/cfg_data_i write a register, while idle.
// Latency and throughput
//   All work for an input is done in the cycle it is accepted; its results
//   (up to three) land in a four-entry result queue in the cycle after
//   acceptance and leave one per cycle while m_axis_tready is high. An input
//   is taken whenever the queue holds at most one result, so after a
//   three-result item the queue must drain to one result before the next
//   item is taken; items with fewer results go faster.
// Reset
//   rst_ni clears the queue, loads register defaults, servo angle 0,
//   upward sweep, agreement counts 255 and done mask 11.
// Stall
//   When m_axis_tready is low results wait in the queue; once two or more
//   are pending s_axis_tready drops until the queue drains.

module servo_sweep_echo_obstacle_reporter_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sensor_sample[11:0], echo_channel[13:12], echo_level[14], time_ms[46:15]
  input  logic [ssecho_pkg::InDataBits-1:0] s_axis_tdata,
  // req_type
  input  logic                             s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // servo_compare[11:0], fire_trigger[12], payload[20:13]
  output logic [ssecho_pkg::OutDataBits-1:0] m_axis_tdata,
  // result_kind
  output logic [1:0]                       m_axis_tuser,
  output logic                             m_axis_tlast,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [ssecho_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [ssecho_pkg::CfgDataBits-1:0] cfg_data_i
);

  // configuration registers
  logic signed [7:0] sweep_min_q, sweep_max_q;
  logic [6:0]        sweep_step_q;
  logic [7:0]        near_thr_q, hyst_q, stable_q;
  logic [3:0]        trig_mask_q;

  // block state
  logic signed [7:0] servo_angle_q, servo_angle_d;
  logic              sweep_up_q, sweep_up_d;
  logic [11:0]       peak_sample_q, peak_sample_d;
  logic signed [7:0] peak_angle_q, peak_angle_d;
  logic signed [7:0] latched_q, latched_d;
  logic signed [7:0] sent_angle_q, sent_angle_d;
  logic [3:0]        flags_q, flags_d;
  logic [3:0]        sent_flags_q, sent_flags_d;
  logic [3:0]        done_mask_q, done_mask_d;
  logic [ssecho_pkg::CountBits-1:0] agree_q [ssecho_pkg::NumRangers];
  logic [ssecho_pkg::CountBits-1:0] agree_d [ssecho_pkg::NumRangers];
  logic [ssecho_pkg::TimeBits-1:0]  edge_q  [ssecho_pkg::NumRangers];
  logic [ssecho_pkg::TimeBits-1:0]  edge_d  [ssecho_pkg::NumRangers];

  // result queue
  ssecho_pkg::result_t fifo_q [ssecho_pkg::FifoDepth];
  ssecho_pkg::result_t fifo_d [ssecho_pkg::FifoDepth];
  logic [ssecho_pkg::PtrBits-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ssecho_pkg::FillBits-1:0] fill_q, fill_d;

  // input field split
  logic                              in_acc, out_pop;
  logic [11:0]                       in_sample;
  logic [ssecho_pkg::ChBits-1:0]     in_ch;
  logic                              in_level;
  logic [ssecho_pkg::TimeBits-1:0]   in_time;

  assign in_sample = s_axis_tdata[11:0];
  assign in_ch     = s_axis_tdata[13:12];
  assign in_level  = s_axis_tdata[14];
  assign in_time   = s_axis_tdata[46:15];

  assign s_axis_tready = (fill_q <= 3'd1);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_pop       = m_axis_tvalid & m_axis_tready;

  // per-item working signals
  ssecho_pkg::result_t       res [ssecho_pkg::MaxRes];
  logic [1:0]                n_res;
  logic                      do_report, all_stable, fire;
  logic signed [9:0]         step_s, a_raw, hi_lim, lo_lim, ang_diff, hyst_s;
  logic signed [7:0]         a_sat;
  logic signed [12:0]        cmp_full;
  logic [ssecho_pkg::TimeBits-1:0] width;
  logic [3:0]                ch_bit;
  logic                      old_flag, near;

  // single-pass update of state and results for an accepted item
  always_comb begin
    servo_angle_d = servo_angle_q;
    sweep_up_d    = sweep_up_q;
    peak_sample_d = peak_sample_q;
    peak_angle_d  = peak_angle_q;
    latched_d     = latched_q;
    sent_angle_d  = sent_angle_q;
    flags_d       = flags_q;
    sent_flags_d  = sent_flags_q;
    done_mask_d   = done_mask_q;
    for (int i = 0; i < ssecho_pkg::NumRangers; i++) begin
      agree_d[i] = agree_q[i];
      edge_d[i]  = edge_q[i];
    end
    for (int k = 0; k < ssecho_pkg::MaxRes; k++) begin
      res[k] = '0;
    end
    n_res     = 2'd0;
    do_report = 1'b0;
    fire      = 1'b0;
    step_s    = signed'({3'b000, sweep_step_q});
    a_raw     = '0;
    a_sat     = '0;
    hi_lim    = '0;
    lo_lim    = '0;
    cmp_full  = '0;
    width     = '0;
    ch_bit    = 4'(1) << in_ch;
    old_flag  = flags_q[in_ch];
    near      = 1'b0;
    all_stable = 1'b1;
    ang_diff  = '0;
    hyst_s    = signed'({2'b00, hyst_q});

    if (in_acc) begin
      if (s_axis_tuser == ssecho_pkg::ReqSweep) begin
        // peak tracking on the angle before the move
        if (in_sample >= peak_sample_q) begin
          peak_sample_d = in_sample;
          peak_angle_d  = servo_angle_q;
        end
        // step and saturate the servo angle
        a_raw = sweep_up_q ? (10'(servo_angle_q) + step_s) : (10'(servo_angle_q) - step_s);
        if (a_raw > 10'sd127) begin
          a_sat = 8'sd127;
        end else if (a_raw < -10'sd128) begin
          a_sat = -8'sd128;
        end else begin
          a_sat = a_raw[7:0];
        end
        servo_angle_d = a_sat;
        // end of sweep: reverse and latch the peak
        hi_lim = 10'(sweep_max_q) - step_s;
        lo_lim = 10'(sweep_min_q) + step_s;
        if (10'(a_sat) > hi_lim || 10'(a_sat) < lo_lim) begin
          sweep_up_d    = ~sweep_up_q;
          latched_d     = peak_angle_d;
          peak_sample_d = '0;
        end
        // servo result with optional trigger
        cmp_full = 13'(a_sat) * ssecho_pkg::CmpScale + ssecho_pkg::CmpOffset;
        fire     = (done_mask_q == trig_mask_q);
        if (fire) begin
          done_mask_d = '0;
        end
        res[0].kind    = ssecho_pkg::KindServo;
        res[0].compare = cmp_full[11:0];
        res[0].fire    = fire;
        n_res          = 2'd1;
        do_report      = 1'b1;
      end else if (int'(in_ch) < ssecho_pkg::NumRangers && !in_level) begin
        // falling edge: pulse width and agreement count
        width          = in_time - edge_q[in_ch];
        edge_d[in_ch]  = width;
        near           = (width <= 32'(near_thr_q));
        if (near == old_flag) begin
          if (agree_q[in_ch] != ssecho_pkg::CountMax) begin
            agree_d[in_ch] = agree_q[in_ch] + 8'd1;
          end
        end else begin
          agree_d[in_ch] = '0;
        end
        flags_d     = near ? (flags_q | ch_bit) : (flags_q & ~ch_bit);
        done_mask_d = done_mask_q | ch_bit;
        do_report   = 1'b1;
      end else if (int'(in_ch) < ssecho_pkg::NumRangers) begin
        // rising edge: remember the time
        edge_d[in_ch] = in_time;
      end
    end

    // reports on the updated state
    if (do_report) begin
      for (int i = 0; i < ssecho_pkg::NumRangers; i++) begin
        if (agree_d[i] < stable_q) begin
          all_stable = 1'b0;
        end
      end
      if (all_stable && flags_d != sent_flags_q) begin
        sent_flags_d          = flags_d;
        res[n_res].kind       = ssecho_pkg::KindFlags;
        res[n_res].payload    = {4'b0000, flags_d};
        n_res                 = n_res + 2'd1;
      end
      ang_diff = 10'(latched_d) - 10'(sent_angle_q);
      if (ang_diff > hyst_s || ang_diff < -hyst_s) begin
        sent_angle_d          = latched_d;
        res[n_res].kind       = ssecho_pkg::KindAngle;
        res[n_res].payload    = latched_d;
        n_res                 = n_res + 2'd1;
      end
      // an echo edge may leave nothing to report
      if (n_res != 2'd0) begin
        res[n_res - 2'd1].last = 1'b1;
      end
    end
  end

  // queue bookkeeping
  always_comb begin
    for (int j = 0; j < ssecho_pkg::FifoDepth; j++) begin
      fifo_d[j] = fifo_q[j];
    end
    for (int k = 0; k < ssecho_pkg::MaxRes; k++) begin
      if (k < int'(n_res)) begin
        fifo_d[wr_ptr_q + ssecho_pkg::PtrBits'(k)] = res[k];
      end
    end
    wr_ptr_d = wr_ptr_q + ssecho_pkg::PtrBits'(n_res);
    rd_ptr_d = rd_ptr_q + ssecho_pkg::PtrBits'(out_pop);
    fill_d   = fill_q + ssecho_pkg::FillBits'(n_res) - ssecho_pkg::FillBits'(out_pop);
  end

  // output port mapping
  assign m_axis_tvalid = (fill_q != '0);
  assign m_axis_tuser  = fifo_q[rd_ptr_q].kind;
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;
  assign m_axis_tdata  = {3'b000, fifo_q[rd_ptr_q].payload, fifo_q[rd_ptr_q].fire,
                          fifo_q[rd_ptr_q].compare};

  // queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < ssecho_pkg::FifoDepth; j++) begin
      fifo_q[j] <= fifo_d[j];
    end
  end

  // control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_min_q   <= ssecho_pkg::SweepMinRst;
      sweep_max_q   <= ssecho_pkg::SweepMaxRst;
      sweep_step_q  <= ssecho_pkg::SweepStepRst;
      near_thr_q    <= ssecho_pkg::NearThrRst;
      hyst_q        <= ssecho_pkg::HystRst;
      stable_q      <= ssecho_pkg::StableRst;
      trig_mask_q   <= ssecho_pkg::TrigMaskRst;
      servo_angle_q <= '0;
      sweep_up_q    <= 1'b1;
      peak_sample_q <= '0;
      peak_angle_q  <= '0;
      latched_q     <= '0;
      sent_angle_q  <= '0;
      flags_q       <= '0;
      sent_flags_q  <= '0;
      done_mask_q   <= ssecho_pkg::DoneMaskRst;
      for (int i = 0; i < ssecho_pkg::NumRangers; i++) begin
        agree_q[i] <= ssecho_pkg::CountMax;
        edge_q[i]  <= '0;
      end
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      servo_angle_q <= servo_angle_d;
      sweep_up_q    <= sweep_up_d;
      peak_sample_q <= peak_sample_d;
      peak_angle_q  <= peak_angle_d;
      latched_q     <= latched_d;
      sent_angle_q  <= sent_angle_d;
      flags_q       <= flags_d;
      sent_flags_q  <= sent_flags_d;
      done_mask_q   <= done_mask_d;
      for (int i = 0; i < ssecho_pkg::NumRangers; i++) begin
        agree_q[i] <= agree_d[i];
        edge_q[i]  <= edge_d[i];
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ssecho_pkg::CfgSweepMin:  sweep_min_q  <= cfg_data_i;
          ssecho_pkg::CfgSweepMax:  sweep_max_q  <= cfg_data_i;
          ssecho_pkg::CfgSweepStep: sweep_step_q <= cfg_data_i[6:0];
          ssecho_pkg::CfgNearThr:   near_thr_q   <= cfg_data_i;
          ssecho_pkg::CfgHyst:      hyst_q       <= cfg_data_i;
          ssecho_pkg::CfgStable:    stable_q     <= cfg_data_i;
          ssecho_pkg::CfgTrigMask:  trig_mask_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 3'(ssecho_pkg::FifoDepth))
    else $error("result queue overflow");

  // every sweep step leaves at least its servo result queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == ssecho_pkg::ReqSweep) |=> (fill_q != '0))
    else $error("sweep step produced no result");

  // a firing trigger clears the done mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == ssecho_pkg::ReqSweep && done_mask_q == trig_mask_q)
    |=> (done_mask_q == '0))
    else $error("done mask not cleared after trigger");

  // trigger pulse only rides on servo results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[12]) |-> (m_axis_tuser == ssecho_pkg::KindServo))
    else $error("trigger on non-servo result");

  // a rising edge adds nothing to the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == ssecho_pkg::ReqEcho && in_level) |=> (fill_q <= $past(fill_q)))
    else $error("rising edge produced a result");

endmodule
